>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_IMPLIES(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(name, clk, rst, ante, cons)
`define ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

>>> design/scf_pkg.sv
// ----------------------------------------------------------------------------
// scf_pkg
// Shared constants and types of the sum checksum frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package scf_pkg;

   localparam logic [7:0] HEADER_BYTE   = 8'hFF;
   localparam logic [7:0] RESERVED_BYTE = 8'h00;

   localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
   localparam logic [1:0] KIND_ACCEPT   = 2'd1;
   localparam logic [1:0] KIND_REJECT   = 2'd2;
   localparam logic [1:0] KIND_UNUSED   = 2'd3;

   localparam logic [1:0] ERR_BAD_RESERVED = 2'd0;
   localparam logic [1:0] ERR_CMD_MISMATCH = 2'd1;
   localparam logic [1:0] ERR_BAD_CHECKSUM = 2'd2;
   localparam logic [1:0] ERR_ZERO_LENGTH  = 2'd3;

   localparam int unsigned CSR_ADDR_W = 2;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] ADDR_EXPECTED_COMMAND = 2'd0;

   typedef struct packed {
      logic       valid;
      logic [1:0] item_kind;
      logic [7:0] payload_byte;
      logic [7:0] byte_index;
      logic [7:0] payload_count;
      logic [1:0] error_code;
      logic       frame_end;
   } result_type;

endpackage

`default_nettype wire

>>> design/scf_csr.sv
// ----------------------------------------------------------------------------
// scf_csr
// APB register file holding the expected command code.
// ----------------------------------------------------------------------------
`default_nettype none

module scf_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [scf_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire logic [scf_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic      [scf_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                                  pready,
   output logic      [7:0]                       expected_command
);
   import scf_pkg::*;

   logic [7:0] exp_cmd_ff;
   logic [7:0] exp_cmd_in;
   logic       wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && (paddr == ADDR_EXPECTED_COMMAND);

   always_comb begin
      exp_cmd_in = exp_cmd_ff;
      if (wr_en) begin
         exp_cmd_in = pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_cmd_ff <= 8'd0;
      end else begin
         exp_cmd_ff <= exp_cmd_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr == ADDR_EXPECTED_COMMAND) begin
         prdata = {{(CSR_DATA_W-8){1'b0}}, exp_cmd_ff};
      end
   end

   assign expected_command = exp_cmd_ff;

endmodule

`default_nettype wire

>>> design/scf_parse.sv
// ----------------------------------------------------------------------------
// scf_parse
// Input register and frame parser: phase, running sum, length and position.
// ----------------------------------------------------------------------------
`default_nettype none

module scf_parse (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic [7:0]            req_rx_byte,
   output logic                       req_stall,
   input  wire logic                  advance,
   input  wire logic [7:0]            expected_command,
   output scf_pkg::result_type        result
);
   import scf_pkg::*;

   typedef enum logic [2:0] {
      PH_HUNT     = 3'd0,
      PH_RESERVED = 3'd1,
      PH_LENGTH   = 3'd2,
      PH_COMMAND  = 3'd3,
      PH_DATA     = 3'd4,
      PH_CHECK    = 3'd5
   } phase_type;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff,  in_byte_in;
   phase_type  phase_ff,    phase_in;
   logic [7:0] sum_ff,      sum_in;
   logic [7:0] len_ff,      len_in;
   logic [7:0] pos_ff,      pos_in;
   logic       fire;
   result_type res;

   assign req_stall = in_valid_ff && !advance;
   assign fire      = in_valid_ff && advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
         if (req_valid) begin
            in_byte_in = req_rx_byte;
         end
      end
   end

   always_comb begin
      phase_in = phase_ff;
      sum_in   = sum_ff;
      len_in   = len_ff;
      pos_in   = pos_ff;
      res      = '0;
      case (phase_ff)
         PH_RESERVED: begin
            if (in_byte_ff != RESERVED_BYTE) begin
               phase_in       = PH_HUNT;
               res.valid      = 1'b1;
               res.item_kind  = KIND_REJECT;
               res.error_code = ERR_BAD_RESERVED;
               res.frame_end  = 1'b1;
            end else begin
               phase_in = PH_LENGTH;
            end
         end
         PH_LENGTH: begin
            len_in   = in_byte_ff;
            sum_in   = in_byte_ff;
            phase_in = PH_COMMAND;
         end
         PH_COMMAND: begin
            sum_in = sum_ff + in_byte_ff;
            if (in_byte_ff != expected_command) begin
               phase_in       = PH_HUNT;
               res.valid      = 1'b1;
               res.item_kind  = KIND_REJECT;
               res.error_code = ERR_CMD_MISMATCH;
               res.frame_end  = 1'b1;
            end else begin
               pos_in   = 8'd0;
               phase_in = (len_ff <= 8'd1) ? PH_CHECK : PH_DATA;
            end
         end
         PH_DATA: begin
            sum_in = sum_ff + in_byte_ff;
            pos_in = pos_ff + 8'd1;
            // length is at least two here
            if (pos_in >= len_ff - 8'd1) begin
               phase_in = PH_CHECK;
            end
            res.valid        = 1'b1;
            res.item_kind    = KIND_PAYLOAD;
            res.payload_byte = in_byte_ff;
            res.byte_index   = pos_ff;
         end
         PH_CHECK: begin
            phase_in      = PH_HUNT;
            res.valid     = 1'b1;
            res.frame_end = 1'b1;
            if (in_byte_ff != sum_ff) begin
               res.item_kind  = KIND_REJECT;
               res.error_code = ERR_BAD_CHECKSUM;
            end else if (len_ff == 8'd0) begin
               res.item_kind  = KIND_REJECT;
               res.error_code = ERR_ZERO_LENGTH;
            end else begin
               res.item_kind     = KIND_ACCEPT;
               res.payload_count = len_ff - 8'd1;
            end
         end
         default: begin
            phase_in = (in_byte_ff == HEADER_BYTE) ? PH_RESERVED : PH_HUNT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         phase_ff    <= PH_HUNT;
         sum_ff      <= 8'd0;
         len_ff      <= 8'd0;
         pos_ff      <= 8'd0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (fire) begin
            phase_ff <= phase_in;
            sum_ff   <= sum_in;
            len_ff   <= len_in;
            pos_ff   <= pos_in;
         end
      end
      in_byte_ff <= in_byte_in;
   end

   always_comb begin
      result       = res;
      result.valid = in_valid_ff && res.valid;
   end

endmodule

`default_nettype wire

>>> design/scf_outreg.sv
// ----------------------------------------------------------------------------
// scf_outreg
// Result register; holds an item until the receiving side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module scf_outreg (
   input  wire logic            clock,
   input  wire logic            reset,
   input  scf_pkg::result_type  result,
   output logic                 advance,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output logic [1:0]           rsp_item_kind,
   output logic [7:0]           rsp_payload_byte,
   output logic [7:0]           rsp_byte_index,
   output logic [7:0]           rsp_payload_count,
   output logic [1:0]           rsp_error_code,
   output logic                 rsp_frame_end
);
   import scf_pkg::*;

   logic       out_valid_ff;
   result_type out_data_ff;

   assign advance = !out_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= result.valid;
      end
      if (advance && result.valid) begin
         out_data_ff <= result;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_item_kind     = out_data_ff.item_kind;
   assign rsp_payload_byte  = out_data_ff.payload_byte;
   assign rsp_byte_index    = out_data_ff.byte_index;
   assign rsp_payload_count = out_data_ff.payload_count;
   assign rsp_error_code    = out_data_ff.error_code;
   assign rsp_frame_end     = out_data_ff.frame_end;

endmodule

`default_nettype wire

>>> design/sum_checksum_frame_receiver.sv
// Bytes wait in the input register, results in the result register; each
// holds one item. Throughput: one byte per cycle unless stalled; the input
// side stalls only while both registers are full and rsp_stall is high.
// Reset (synchronous, active high) returns the parser to header hunting,
// empties both registers and clears the expected command to zero.
// ----------------------------------------------------------------------------
// sum_checksum_frame_receiver
// Header/length frame deframer with an 8-bit sum checksum.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sum_checksum_frame_receiver (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [7:0]                       req_rx_byte,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic      [1:0]                       rsp_item_kind,
   output logic      [7:0]                       rsp_payload_byte,
   output logic      [7:0]                       rsp_byte_index,
   output logic      [7:0]                       rsp_payload_count,
   output logic      [1:0]                       rsp_error_code,
   output logic                                  rsp_frame_end,
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [scf_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire logic [scf_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic      [scf_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                                  pready
);
   import scf_pkg::*;

   logic [7:0] expected_command;
   logic       advance;
   result_type result;

   scf_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready),
      .expected_command (expected_command)
   );

   scf_parse u_parse (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_rx_byte      (req_rx_byte),
      .req_stall        (req_stall),
      .advance          (advance),
      .expected_command (expected_command),
      .result           (result)
   );

   scf_outreg u_outreg (
      .clock             (clock),
      .reset             (reset),
      .result            (result),
      .advance           (advance),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_item_kind     (rsp_item_kind),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_byte_index    (rsp_byte_index),
      .rsp_payload_count (rsp_payload_count),
      .rsp_error_code    (rsp_error_code),
      .rsp_frame_end     (rsp_frame_end)
   );

   `ASSERT_IMPLIES(a_end_matches_kind, clock, reset, rsp_valid, rsp_frame_end == (rsp_item_kind != KIND_PAYLOAD))
   `ASSERT_IMPLIES(a_kind_in_range, clock, reset, rsp_valid, rsp_item_kind != KIND_UNUSED)
   `ASSERT_IMPLIES(a_payload_clean, clock, reset, rsp_valid && (rsp_item_kind == KIND_PAYLOAD), (rsp_error_code == ERR_BAD_RESERVED) && (rsp_payload_count == 8'd0))
   `ASSERT_NEXT(a_new_result_loaded, clock, reset, result.valid && advance, rsp_valid)

endmodule

`default_nettype wire
